@@ design/smhr_pkg.sv @@
// ----------------------------------------------------------------------------
// smhr_pkg: shared types and codes for the middle/half-reverse stack
// Operation and status codes plus the word formats of both channels.
// ----------------------------------------------------------------------------
package smhr_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_MIDDLE  = 3'd2;
  localparam logic [2:0] OP_REVERSE = 3'd3;
  localparam logic [2:0] OP_DUMP    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] push_value;
  } smhr_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } smhr_out_t;

endpackage

@@ design/smhr_ram.sv @@
// ----------------------------------------------------------------------------
// smhr_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// value while the read enable is low.
// ----------------------------------------------------------------------------
module smhr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/stack_with_middle_and_half_reverse_core.sv @@
// ----------------------------------------------------------------------------
// stack_with_middle_and_half_reverse_core: bounded LIFO stack of 32-bit words
// Push, pop, middle read, bottom-half reverse and top-to-bottom dump, all
// through one single-port-read entry RAM driven by a small sequencer.
// ----------------------------------------------------------------------------
// Push, pop, middle and the full/empty answers stall the input through the accept
// cycle and the S_EMIT state that loads the result register. Reverse steps through
// S_REV_A, S_REV_B and S_REV_C for each swap: each swap is a read, a read and two writes.
// Dump gives one word per cycle, after a first read, while the result register is not
// stalled; a stalled full result register holds the sequencer. Reset clears the fill
// count, the sequencer and the output valid; the entry RAM is not cleared.
module stack_with_middle_and_half_reverse_core
  import smhr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  smhr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output smhr_out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_DUMP
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    count_q;
  logic [AW-1:0]    i_q;
  logic [AW-1:0]    j_q;
  logic [DATA_W-1:0] tmp_q;
  logic [1:0]       res_status_q;
  logic             res_rd_q;
  logic             out_valid_q;
  smhr_out_t        out_q;

  logic              in_accept;
  logic              slot_free;
  logic              out_load;
  logic              full;
  logic              empty;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     half;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     mid_addr;
  logic [AW-1:0]     i_nxt;
  logic [AW-1:0]     j_nxt;
  logic              more_swaps;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_load    = slot_free && (state_q == S_EMIT || state_q == S_DUMP);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign count_m1   = count_q - 1'b1;
  assign half       = count_q >> 1;
  assign top_addr   = count_m1[AW-1:0];
  assign mid_addr   = AW'(count_m1 >> 1);
  assign i_nxt      = i_q + 1'b1;
  assign j_nxt      = j_q - 1'b1;
  assign more_swaps = (i_nxt < j_nxt);

  // RAM port control. Each reverse swap reads i, reads j, then writes both.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = in_data_i.push_value;
    ram_re    = 1'b0;
    ram_raddr = i_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data_i.op == OP_PUSH) begin
            ram_we = !full;
          end else if (!empty) begin
            if (in_data_i.op == OP_POP || in_data_i.op == OP_DUMP) begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
            end else if (in_data_i.op == OP_MIDDLE) begin
              ram_re    = 1'b1;
              ram_raddr = mid_addr;
            end else if (in_data_i.op == OP_REVERSE) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
          end
        end
      end
      S_REV_A: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
      end
      S_REV_B: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      S_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = tmp_q;
        ram_re    = more_swaps;
        ram_raddr = i_nxt;
      end
      S_DUMP: begin
        ram_re    = slot_free && (i_q != '0);
        ram_raddr = i_q - 1'b1;
      end
      default: ;
    endcase
  end

  smhr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      tmp_q        <= '0;
      res_status_q <= ST_OK;
      res_rd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (in_data_i.op == OP_PUSH) begin
              res_rd_q <= 1'b0;
              if (full) begin
                res_status_q <= ST_FULL;
              end else begin
                res_status_q <= ST_OK;
                count_q      <= count_q + 1'b1;
              end
              state_q <= S_EMIT;
            end else if (in_data_i.op <= OP_DUMP) begin
              if (empty) begin
                res_status_q <= ST_EMPTY;
                res_rd_q     <= 1'b0;
                state_q      <= S_EMIT;
              end else if (in_data_i.op == OP_POP) begin
                count_q      <= count_m1;
                res_status_q <= ST_OK;
                res_rd_q     <= 1'b1;
                state_q      <= S_EMIT;
              end else if (in_data_i.op == OP_MIDDLE) begin
                res_status_q <= ST_OK;
                res_rd_q     <= 1'b1;
                state_q      <= S_EMIT;
              end else if (in_data_i.op == OP_REVERSE) begin
                // A bottom half shorter than two entries stays as it is.
                res_status_q <= ST_OK;
                res_rd_q     <= 1'b0;
                i_q          <= '0;
                j_q          <= AW'(half - 1'b1);
                if (half >= CW'(2)) begin
                  state_q <= S_REV_A;
                end else begin
                  state_q <= S_EMIT;
                end
              end else begin
                i_q     <= top_addr;
                state_q <= S_DUMP;
              end
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_q.status  <= res_status_q;
            out_q.data    <= res_rd_q ? ram_rdata : '0;
            out_q.last    <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        S_REV_A: begin
          tmp_q   <= ram_rdata;
          state_q <= S_REV_B;
        end
        S_REV_B: begin
          state_q <= S_REV_C;
        end
        S_REV_C: begin
          i_q <= i_nxt;
          j_q <= j_nxt;
          if (more_swaps) begin
            state_q <= S_REV_A;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            out_q.status <= ST_OK;
            out_q.data   <= ram_rdata;
            out_q.last   <= (i_q == '0);
            if (i_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              i_q <= i_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/stack_with_middle_and_half_reverse_core_tb.sv @@
// ----------------------------------------------------------------------------
// stack_with_middle_and_half_reverse_core_tb: self-checking bench for the stack
// Drives push, pop, middle, reverse and dump words through the input channel
// and checks every result word against a behavioral stack kept in the bench.
// ----------------------------------------------------------------------------
module stack_with_middle_and_half_reverse_core_tb;
  import smhr_pkg::*;

  localparam int unsigned DEPTH = 16;

  // Op codes the block ignores.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  smhr_in_t  in_word = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  smhr_out_t out_data_o;

  stack_with_middle_and_half_reverse_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bench copy of the stack.
  logic signed [DATA_W-1:0] stack_mem [DEPTH];
  int unsigned              stack_fill = 0;
  smhr_out_t                pending_results[$];

  int fault_count    = 0;
  int results_seen   = 0;
  int full_answers   = 0;
  int empty_answers  = 0;
  int op_seen [8]    = '{default: 0};
  int burst_left     = 0;
  int calm_items     = 0;
  int stall_mode     = 0;
  int stall_left     = 0;
  int stall_phase    = 0;

  // Works out the result words of one accepted word and updates the stack.
  function automatic void apply_stack_op(smhr_in_t w);
    smhr_out_t                r;
    logic signed [DATA_W-1:0] t;
    int unsigned              half;
    int unsigned              k;
    r = '0;
    r.last = 1'b1;
    if (w.op > OP_DUMP) return;
    if (w.op != OP_PUSH && stack_fill == 0) begin
      r.status = ST_EMPTY;
      pending_results.push_back(r);
      return;
    end
    case (w.op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = w.push_value;
          stack_fill++;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        stack_fill--;
        r.status = ST_OK;
        r.data = stack_mem[stack_fill];
      end
      OP_MIDDLE: begin
        r.status = ST_OK;
        r.data = stack_mem[(stack_fill - 1) / 2];
      end
      OP_REVERSE: begin
        half = stack_fill / 2;
        for (k = 0; k < half / 2; k++) begin
          t = stack_mem[k];
          stack_mem[k] = stack_mem[half - 1 - k];
          stack_mem[half - 1 - k] = t;
        end
        r.status = ST_OK;
      end
      default: begin
        for (k = stack_fill; k > 0; k--) begin
          r.status = ST_OK;
          r.data = stack_mem[k - 1];
          r.last = (k == 1);
          pending_results.push_back(r);
        end
        return;
      end
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what);
    fault_count++;
    if (fault_count <= 30) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    smhr_out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word status=%0d data=%0d last=%0d",
                                  out_data_o.status, out_data_o.data, out_data_o.last));
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL) full_answers++;
        if (want.status == ST_EMPTY) empty_answers++;
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data_o.status,
                                    want.status));
        if (out_data_o.data !== want.data)
          report_mismatch($sformatf("data %0d, expected %0d", out_data_o.data, want.data));
        if (out_data_o.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_data_o.last, want.last));
      end
    end
  end

  // Receiver stall pattern: switches at random among four stall characters.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % 5;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_phase < 2);
    endcase
  end

  // Sends one word and waits for it to be taken; gaps come between bursts.
  task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
    smhr_in_t w;
    w.op = op;
    w.push_value = value;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_stack_op(w);
    op_seen[op]++;
    if (calm_items > 0) begin
      calm_items--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_stack();
    send_word(OP_POP, pick_word());
    send_word(OP_MIDDLE, pick_word());
    send_word(OP_REVERSE, pick_word());
    send_word(OP_DUMP, pick_word());
  endtask

  task automatic test_extreme_words();
    send_word(OP_PUSH, 32'sh8000_0000);
    send_word(OP_PUSH, 32'sh7fff_ffff);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, -1);
    send_word(OP_MIDDLE, '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_DUMP, '0);
    send_word(OP_POP, '0);
    // Three entries leave a bottom half of one word, so nothing moves.
    send_word(OP_REVERSE, '0);
    send_word(OP_MIDDLE, '0);
  endtask

  task automatic test_spare_ops();
    send_word(OP_SPARE_A, -1);
    send_word(OP_SPARE_B, 32'sh5555_aaaa);
    send_word(OP_SPARE_C, 32'sh7fff_ffff);
    send_word(OP_MIDDLE, '0);
  endtask

  task automatic test_full_stack();
    while (stack_fill < DEPTH) send_word(OP_PUSH, pick_word());
    send_word(OP_PUSH, 32'sh1234_5678);
    send_word(OP_REVERSE, '0);
    send_word(OP_MIDDLE, '0);
    send_word(OP_DUMP, '0);
    send_word(OP_POP, '0);
  endtask

  task automatic test_random_mix();
    int         done;
    int         r;
    int         push_w;
    logic [2:0] op;
    bit         paused;
    bit         calmed;
    done = 0;
    push_w = 55;
    paused = 1'b0;
    calmed = 1'b0;
    while (done < 140) begin
      if (done % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: push_w = 25;
          1: push_w = 55;
          default: push_w = 85;
        endcase
      end
      if (done >= 60 && !calmed) begin
        calmed = 1'b1;
        calm_items = 25;
      end
      if (done >= 110 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_SPARE_A + 3'($urandom_range(0, 2));
      else if (r < push_w) op = OP_PUSH;
      else op = OP_POP + 3'($urandom_range(0, 3));
      send_word(op, pick_word());
      if (op <= OP_DUMP) done++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_extreme_words();
    test_spare_ops();
    test_full_stack();
    test_random_mix();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Ran push %0d, pop %0d, middle %0d, reverse %0d, dump %0d, ignored %0d words.",
             op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_MIDDLE], op_seen[OP_REVERSE],
             op_seen[OP_DUMP], op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B] +
             op_seen[OP_SPARE_C]);
    $display("Checked %0d result words, %0d full and %0d empty answers among them.",
             results_seen, full_answers, empty_answers);
    if (fault_count == 0) begin
      $display("stack_with_middle_and_half_reverse_core: match");
    end else begin
      $display("stack_with_middle_and_half_reverse_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d result words outstanding.", pending_results.size());
    $display("stack_with_middle_and_half_reverse_core: mismatch");
    $finish;
  end

endmodule
